### src/ecq_pkg.sv
// ----------------------------------------------------------------------------
// ecq_pkg
// Shared types and constants for the extent coverage query block.
// ----------------------------------------------------------------------------
`default_nettype none

package ecq_pkg;

	// table geometry
	localparam int MAX_EXTENTS = 1024;
	localparam int IDX_W       = $clog2(MAX_EXTENTS);
	localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
	localparam int BLK_W       = 64;
	localparam int ENT_W       = 2 * BLK_W;

	// operation codes
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// input word
	typedef struct packed {
		op_t              operation;
		logic [BLK_W-1:0] block_start;
		logic [BLK_W-1:0] block_length;
	} req_word_t;

	// result word
	typedef struct packed {
		logic covered;
		logic rejected;
	} rsp_word_t;

	// one stored extent: first block and exclusive limit
	typedef struct packed {
		logic [BLK_W-1:0] first;
		logic [BLK_W-1:0] limit;
	} ext_t;

	// controller to extent RAM
	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		ext_t             wr_ent;
		logic [IDX_W-1:0] rd_addr;
	} mem_req_t;

endpackage

`default_nettype wire

### src/extent_coverage_query.sv
// ----------------------------------------------------------------------------
// extent_coverage_query
// Table of allocated block extents with clear, append and coverage query.
// ----------------------------------------------------------------------------
// Extents live in one 1024 x 128 synchronous RAM (first block, exclusive
// limit) with a single read port, so a query reads one entry per cycle: it
// takes the word, runs the binary search (ceil(log2(count+1)) steps, at most
// 11 for a full table), walks the extents forward and hands the result to
// the output register. Clear, append, unused operations, queries that are
// empty or overflow and queries on an empty table go from taking the word
// straight to the result. The next word is taken while the previous result
// still waits in the output register. The table keeps its entries in order
// of start; the caller must append in that order, it is not checked.
// ----------------------------------------------------------------------------
`default_nettype none

module extent_coverage_query
	import ecq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire req_word_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output rsp_word_t      rsp
);

	mem_req_t         mem_req;
	logic [ENT_W-1:0] rd_data;
	ext_t             rd_ent;

	assign rd_ent = ext_t'(rd_data);

	// sequencer and result register
	ecq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.mem_req   (mem_req),
		.rd_ent    (rd_ent)
	);

	// extent store
	ecq_ram #(
		.DEPTH (MAX_EXTENTS),
		.WIDTH (ENT_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.wr_addr),
		.wr_data (mem_req.wr_ent),
		.rd_addr (mem_req.rd_addr),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire

### src/ecq_ram.sv
// ----------------------------------------------------------------------------
// ecq_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ecq_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 128,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

### src/ecq_ctrl.sv
// ----------------------------------------------------------------------------
// ecq_ctrl
// Sequencer for the extent table: clear, append, lower-bound binary search
// and forward coverage walk, plus the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ecq_ctrl
	import ecq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire req_word_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output rsp_word_t      rsp,
	output mem_req_t       mem_req,
	input  wire ext_t      rd_ent
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_WALK   = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_EXTENTS);

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] base_q;
	logic [CNT_W-1:0] span_q;
	logic [CNT_W-1:0] idx_q;
	logic [BLK_W-1:0] reach_q;
	logic [BLK_W-1:0] end_q;
	rsp_word_t        res_q;
	logic             rsp_valid_q;
	rsp_word_t        rsp_q;

	logic             accept;
	logic [BLK_W:0]   sum;
	logic             sum_ovf;
	logic [CNT_W-1:0] half;
	logic [CNT_W-1:0] probe;
	logic             probe_hit;
	logic [CNT_W-1:0] nbase;
	logic [CNT_W-1:0] nspan;
	logic [CNT_W-1:0] nprobe;
	logic             idx_in_rng;
	logic             ext_joins;
	logic             ext_reaches;
	logic             slot_free;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign slot_free = !rsp_valid_q || rsp_ready;

	// end of the incoming range, with carry out as overflow
	assign sum     = {1'b0, req.block_start} + {1'b0, req.block_length};
	assign sum_ovf = sum[BLK_W];

	// one binary search step; read data is the limit of the current probe
	always_comb begin
		half      = span_q >> 1;
		probe     = base_q + half;
		probe_hit = (rd_ent.limit <= reach_q);
		if (probe_hit) begin
			nbase = probe + CNT_ONE;
			nspan = span_q - half - CNT_ONE;
		end else begin
			nbase = base_q;
			nspan = half;
		end
		nprobe = nbase + (nspan >> 1);
	end

	// walk step; reach stays below end while walking, so limit >= end alone
	// says the extent finishes the range
	assign idx_in_rng  = (idx_q < count_q);
	assign ext_joins   = (rd_ent.first <= reach_q);
	assign ext_reaches = (rd_ent.limit >= end_q);

	// RAM requests: append writes at the fill point, reads follow the sequencer
	always_comb begin
		mem_req.wr_en          = accept && (req.operation == OP_APPEND)
		                         && (count_q != CNT_MAX) && !sum_ovf;
		mem_req.wr_addr        = count_q[IDX_W-1:0];
		mem_req.wr_ent.first   = req.block_start;
		mem_req.wr_ent.limit   = sum[BLK_W-1:0];
		mem_req.rd_addr        = idx_q[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				mem_req.rd_addr = count_q[CNT_W-1:1];
			end
			ST_SEARCH: begin
				if (nspan == '0) begin
					mem_req.rd_addr = nbase[IDX_W-1:0];
				end else begin
					mem_req.rd_addr = nprobe[IDX_W-1:0];
				end
			end
			ST_WALK: begin
				mem_req.rd_addr = idx_q[IDX_W-1:0] + IDX_W'(1);
			end
			ST_RESULT: begin
				mem_req.rd_addr = idx_q[IDX_W-1:0];
			end
			default: begin
				mem_req.rd_addr = idx_q[IDX_W-1:0];
			end
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				reach_q        <= req.block_start;
				end_q          <= sum[BLK_W-1:0];
				base_q         <= '0;
				span_q         <= count_q;
				res_q.rejected <= (req.operation == OP_APPEND)
				                  && ((count_q == CNT_MAX) || sum_ovf);
				res_q.covered  <= (req.operation == OP_QUERY)
				                  && (req.block_length == '0);
			end
			ST_SEARCH: begin
				base_q <= nbase;
				span_q <= nspan;
				idx_q  <= nbase;
			end
			ST_WALK: begin
				if (idx_in_rng && ext_joins) begin
					res_q.covered <= ext_reaches;
					if (rd_ent.limit > reach_q) begin
						reach_q <= rd_ent.limit;
					end
					idx_q <= idx_q + CNT_ONE;
				end
			end
			ST_RESULT: begin
				res_q <= res_q;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
		if (state_q == ST_RESULT && slot_free) begin
			rsp_q <= res_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// result slot: a new word replaces the one leaving
			if (state_q == ST_RESULT && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.operation == OP_QUERY && req.block_length != '0
						    && !sum_ovf && count_q != '0) begin
							state_q <= ST_SEARCH;
						end else begin
							state_q <= ST_RESULT;
						end
						if (req.operation == OP_CLEAR) begin
							count_q <= '0;
						end else if (mem_req.wr_en) begin
							count_q <= count_q + CNT_ONE;
						end
					end
				end
				ST_SEARCH: begin
					if (nspan == '0) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (!idx_in_rng || !ext_joins || ext_reaches) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
